// File: design/rsmp_pkg.sv
// shared types, constants and helper functions of the polyphase resampler
package rsmp_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 18;
   localparam int COEF_FRAC   = 15;
   localparam int CFG_BITS    = 5;
   localparam int HIST_DEPTH  = 16;
   localparam int COEF_DEPTH  = 256;
   localparam int COEF_AW     = $clog2(COEF_DEPTH);
   localparam int CNT_BITS    = $clog2(HIST_DEPTH);
   localparam int PHASE_BITS  = CFG_BITS;
   localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS    = PROD_BITS + CNT_BITS;
   localparam int SAT_W       = ACC_BITS - COEF_FRAC + 1;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CFG_BITS-1:0] MAX_INTERP         = CFG_BITS'(16);
   localparam logic [CFG_BITS-1:0] TAPS_PER_PHASE_MAX = CFG_BITS'(HIST_DEPTH);
   localparam logic [CNT_BITS-1:0] CNT_LAST           = CNT_BITS'(HIST_DEPTH - 1);

   localparam logic [CSR_IDX_BITS-1:0] CSR_INTERP = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_DECIM  = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_TAPS   = CSR_IDX_BITS'(2);

   localparam logic REQ_COEF   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic signed [ACC_BITS:0] RND_HALF =
      {{(ACC_BITS - COEF_FRAC + 1){1'b0}}, 1'b1, {(COEF_FRAC - 1){1'b0}}};
   localparam logic signed [SAT_W-1:0] SAT_HI =
      {{(SAT_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
   } cplx_type;

   typedef struct packed {
      logic vld;
      logic use_tap;
      logic first;
      logic last;
   } mac_ctl_type;

   function automatic logic [CFG_BITS-1:0] clamp_cfg(input logic [CFG_BITS-1:0] v,
                                                     input logic [CFG_BITS-1:0] hi);
      logic [CFG_BITS-1:0] r;
      if (v == '0) begin
         r = CFG_BITS'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // round half up, then saturate to the sample width
   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
      input logic signed [ACC_BITS-1:0] acc);
      logic signed [ACC_BITS:0]  sum;
      logic signed [SAT_W-1:0]   shr;
      logic signed [SAMPLE_BITS-1:0] r;
      sum = (ACC_BITS + 1)'(acc) + RND_HALF;
      shr = sum[ACC_BITS:COEF_FRAC];
      if (shr > SAT_HI) begin
         r = SAT_HI[SAMPLE_BITS-1:0];
      end else if (shr < SAT_LO) begin
         r = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         r = shr[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// File: design/rsmp_ifs.sv
// request and response channel interfaces of the resampler
interface rsmp_req_if import rsmp_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [7:0]                    tap_index;
   logic signed [COEF_BITS-1:0]   tap_value;
   logic signed [SAMPLE_BITS-1:0] sample_re;
   logic signed [SAMPLE_BITS-1:0] sample_im;

   modport source (output valid, req_type, tap_index, tap_value, sample_re, sample_im,
                   input ready);
   modport sink (input valid, req_type, tap_index, tap_value, sample_re, sample_im,
                 output ready);
endinterface

interface rsmp_rsp_if import rsmp_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_re;
   logic signed [SAMPLE_BITS-1:0] out_im;
   logic                          run_last;

   modport source (output valid, out_re, out_im, run_last, input ready);
   modport sink (input valid, out_re, out_im, run_last, output ready);
endinterface

// File: design/polyphase_rational_resampler_core.sv
// polyphase rational resampler: a sample yields n results (0 to L), and no new request is
// taken until its last result is in the output register; each result walks the 16-cell
// history ring once while the coefficient store's single read port delivers one tap per
// cycle, then the mac pipeline drains; one output register
// reset: synchronous, clears history and phase, then clears all 256 store entries before
// the first request is taken (configuration writes are taken throughout)
module polyphase_rational_resampler_core import rsmp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   rsmp_req_if.sink                req_if,
   rsmp_rsp_if.source              rsp_if,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata
);

   state_type                     state_ff;
   state_type                     state_in;
   logic [COEF_AW-1:0]            clr_cnt_ff;
   logic [COEF_AW-1:0]            clr_cnt_in;
   logic [PHASE_BITS-1:0]         phase_ff;
   logic [PHASE_BITS-1:0]         phase_in;
   logic [COEF_AW-1:0]            addr_ff;
   logic [COEF_AW-1:0]            addr_in;
   logic [CNT_BITS-1:0]           cnt_ff;
   logic [CNT_BITS-1:0]           cnt_in;
   logic [CFG_BITS-1:0]           interp_ff;
   logic [CFG_BITS-1:0]           decim_ff;
   logic [CFG_BITS-1:0]           taps_ff;
   logic                          out_vld_ff;
   logic                          out_vld_in;
   logic signed [SAMPLE_BITS-1:0] out_re_ff;
   logic signed [SAMPLE_BITS-1:0] out_im_ff;
   logic                          out_last_ff;

   logic [CFG_BITS-1:0]           l_eff;
   logic [CFG_BITS-1:0]           d_eff;
   logic [CFG_BITS-1:0]           t_eff;
   logic [PHASE_BITS-1:0]         nphase;
   logic                          run_done;
   logic                          req_acc;
   logic                          acc_sample;
   logic                          acc_coef;
   logic                          out_free;
   logic                          out_load;
   logic                          clr_last;

   logic                          ram_we;
   logic [COEF_AW-1:0]            ram_waddr;
   logic [COEF_BITS-1:0]          ram_wdata;
   logic [COEF_BITS-1:0]          ram_rdata;
   logic                          shift_en;
   logic                          rot_en;
   mac_ctl_type                   mac_ctl;
   logic                          mac_done;
   logic signed [SAMPLE_BITS-1:0] mac_re;
   logic signed [SAMPLE_BITS-1:0] mac_im;
   cplx_type                      new_sample;
   cplx_type                      cell_q [HIST_DEPTH];

   assign l_eff = clamp_cfg(interp_ff, MAX_INTERP);
   assign d_eff = clamp_cfg(decim_ff, MAX_INTERP);
   assign t_eff = clamp_cfg(taps_ff, TAPS_PER_PHASE_MAX);

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_if.valid & req_if.ready;
   assign acc_sample   = req_acc & (req_if.req_type == REQ_SAMPLE);
   assign acc_coef     = req_acc & (req_if.req_type == REQ_COEF);
   assign out_free     = ~out_vld_ff | rsp_if.ready;
   assign clr_last     = (clr_cnt_ff == COEF_AW'(COEF_DEPTH - 1));
   assign nphase       = phase_ff + d_eff;
   assign run_done     = (nphase >= l_eff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (acc_sample && (phase_ff < l_eff)) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = run_done ? ST_IDLE : ST_CALC;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state outputs
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = req_if.tap_index;
      ram_wdata = req_if.tap_value;
      shift_en  = 1'b0;
      rot_en    = 1'b0;
      mac_ctl   = '0;
      out_load  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
            ram_wdata = '0;
         end
         ST_IDLE: begin
            ram_we   = acc_coef;
            shift_en = acc_sample;
         end
         ST_CALC: begin
            rot_en          = 1'b1;
            mac_ctl.vld     = 1'b1;
            mac_ctl.use_tap = (CFG_BITS'(cnt_ff) < t_eff);
            mac_ctl.first   = (cnt_ff == '0);
            mac_ctl.last    = (cnt_ff == CNT_LAST);
         end
         ST_WAIT: begin
            out_load = 1'b0;
         end
         ST_FINISH: begin
            out_load = out_free;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   // datapath and counters
   always_comb begin
      clr_cnt_in = (state_ff == ST_CLEAR) ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      cnt_in     = (state_ff == ST_CALC) ? cnt_ff + 1'b1 : '0;
      phase_in   = phase_ff;
      addr_in    = addr_ff;
      if (state_ff == ST_CALC) begin
         addr_in = addr_ff + COEF_AW'(l_eff);
      end
      if (acc_sample) begin
         // phase already past the last branch: skip the sample
         if (phase_ff >= l_eff) begin
            phase_in = phase_ff - l_eff;
         end
         addr_in = COEF_AW'(phase_ff);
      end
      if (out_load) begin
         phase_in = run_done ? nphase - l_eff : nphase;
         addr_in  = COEF_AW'(nphase);
      end
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         phase_ff   <= '0;
         cnt_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (out_load) begin
         out_re_ff   <= mac_re;
         out_im_ff   <= mac_im;
         out_last_ff <= run_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interp_ff <= CFG_BITS'(1);
         decim_ff  <= CFG_BITS'(1);
         taps_ff   <= CFG_BITS'(16);
      end else if (csr_we) begin
         case (csr_index)
            CSR_INTERP: interp_ff <= csr_wdata;
            CSR_DECIM:  decim_ff  <= csr_wdata;
            CSR_TAPS:   taps_ff   <= csr_wdata;
            default:    interp_ff <= interp_ff;
         endcase
      end
   end

   assign new_sample.re = req_if.sample_re;
   assign new_sample.im = req_if.sample_im;

   // history ring: shift moves entries one place older, rotate brings the next one to cell 0
   for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         rsmp_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (shift_en),
            .rot_en    (rot_en),
            .shift_din (new_sample),
            .rot_din   (cell_q[(k + 1) % HIST_DEPTH]),
            .q         (cell_q[k])
         );
      end else begin : g_body
         rsmp_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (shift_en),
            .rot_en    (rot_en),
            .shift_din (cell_q[k - 1]),
            .rot_din   (cell_q[(k + 1) % HIST_DEPTH]),
            .q         (cell_q[k])
         );
      end
   end

   rsmp_ram #(
      .WIDTH (COEF_BITS),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   rsmp_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .hist   (cell_q[0]),
      .coef   (signed'(ram_rdata)),
      .done   (mac_done),
      .res_re (mac_re),
      .res_im (mac_im)
   );

   assign rsp_if.valid    = out_vld_ff;
   assign rsp_if.out_re   = out_re_ff;
   assign rsp_if.out_im   = out_im_ff;
   assign rsp_if.run_last = out_last_ff;

endmodule

// File: design/rsmp_ram.sv
// generic single write port ram with registered read
module rsmp_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/rsmp_cell.sv
// one history cell: takes a new entry on a shift or its ring neighbor on a rotate
module rsmp_cell import rsmp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     shift_en,
   input  logic     rot_en,
   input  cplx_type shift_din,
   input  cplx_type rot_din,
   output cplx_type q
);

   cplx_type q_ff;
   cplx_type q_in;

   always_comb begin
      q_in = q_ff;
      if (shift_en) begin
         q_in = shift_din;
      end else if (rot_en) begin
         q_in = rot_din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

// File: design/rsmp_mac.sv
// complex multiply-accumulate over one branch, with rounding and saturation of the sum
module rsmp_mac import rsmp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  mac_ctl_type                   ctl,
   input  cplx_type                      hist,
   input  logic signed [COEF_BITS-1:0]   coef,
   output logic                          done,
   output logic signed [SAMPLE_BITS-1:0] res_re,
   output logic signed [SAMPLE_BITS-1:0] res_im
);

   // stage a lines the history value up with the registered coefficient read
   mac_ctl_type                 ctl_a_ff;
   cplx_type                    hist_a_ff;
   mac_ctl_type                 ctl_b_ff;
   logic signed [PROD_BITS-1:0] prod_re_ff;
   logic signed [PROD_BITS-1:0] prod_im_ff;
   logic signed [PROD_BITS-1:0] prod_re_in;
   logic signed [PROD_BITS-1:0] prod_im_in;
   logic signed [ACC_BITS-1:0]  acc_re_ff;
   logic signed [ACC_BITS-1:0]  acc_im_ff;
   logic signed [ACC_BITS-1:0]  acc_re_in;
   logic signed [ACC_BITS-1:0]  acc_im_in;
   logic                        done_ff;
   logic                        done_in;

   always_comb begin
      prod_re_in = '0;
      prod_im_in = '0;
      if (ctl_a_ff.use_tap) begin
         prod_re_in = coef * hist_a_ff.re;
         prod_im_in = coef * hist_a_ff.im;
      end
   end

   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (ctl_b_ff.vld) begin
         if (ctl_b_ff.first) begin
            acc_re_in = ACC_BITS'(prod_re_ff);
            acc_im_in = ACC_BITS'(prod_im_ff);
         end else begin
            acc_re_in = acc_re_ff + ACC_BITS'(prod_re_ff);
            acc_im_in = acc_im_ff + ACC_BITS'(prod_im_ff);
         end
      end
      done_in = ctl_b_ff.vld & ctl_b_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         ctl_a_ff <= ctl;
         ctl_b_ff <= ctl_a_ff;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      hist_a_ff  <= hist;
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
      acc_re_ff  <= acc_re_in;
      acc_im_ff  <= acc_im_in;
   end

   assign done   = done_ff;
   assign res_re = round_sat(acc_re_ff);
   assign res_im = round_sat(acc_im_ff);

endmodule

// File: tb/sv/tb_polyphase_rational_resampler_core.sv
// testbench of the polyphase rational resampler core, self-checking against its own predictor
`timescale 1ns / 100ps

module tb_polyphase_rational_resampler_core;
   import rsmp_pkg::*;

   localparam int SETTLE_CYCLES  = 40;
   localparam int QUIET_LIMIT    = 4000;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_REQUESTS = 30;

   typedef struct {
      logic                          kind;
      logic [7:0]                    tap_index;
      logic signed [COEF_BITS-1:0]   tap_value;
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
   } request_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic                          last;
   } out_sample_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_INTERP;
   logic [CFG_BITS-1:0]     csr_wdata = '0;

   rsmp_req_if req_bus ();
   rsmp_rsp_if rsp_bus ();

   request_type    pending_reqs[$];
   out_sample_type expected_outputs[$];
   int             gap_pct = 24;
   int             errors = 0;
   int             quiet_cycles = 0;

   // predictor state
   logic [CFG_BITS-1:0]           cfg_interp = CFG_BITS'(1);
   logic [CFG_BITS-1:0]           cfg_decim = CFG_BITS'(1);
   logic [CFG_BITS-1:0]           cfg_taps = CFG_BITS'(16);
   logic signed [SAMPLE_BITS-1:0] delay_re[HIST_DEPTH];
   logic signed [SAMPLE_BITS-1:0] delay_im[HIST_DEPTH];
   logic signed [COEF_BITS-1:0]   proto_taps[COEF_DEPTH];
   logic [PHASE_BITS-1:0]         branch_phase = '0;

   polyphase_rational_resampler_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // registers outside 1..16 act as the nearest bound, zero as one
   function automatic int eff_cfg(input logic [CFG_BITS-1:0] v);
      int r;
      r = (v == '0) ? 1 : int'(v);
      if (r > 16) r = 16;
      return r;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] round_to_sample(input longint acc);
      longint v;
      v = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SAMPLE_BITS-1:0];
   endfunction

   function automatic void resample_request(input request_type r);
      int             l_eff, d_eff, t_eff, k, ti, n;
      longint         acc_re, acc_im, h;
      out_sample_type o;
      if (r.kind == REQ_COEF) begin
         proto_taps[r.tap_index] = r.tap_value;
         return;
      end
      l_eff = eff_cfg(cfg_interp);
      d_eff = eff_cfg(cfg_decim);
      t_eff = eff_cfg(cfg_taps);
      for (k = HIST_DEPTH - 1; k > 0; k--) begin
         delay_re[k] = delay_re[k-1];
         delay_im[k] = delay_im[k-1];
      end
      delay_re[0] = r.re;
      delay_im[0] = r.im;
      n = 0;
      while (int'(branch_phase) < l_eff) begin
         acc_re = 0;
         acc_im = 0;
         for (k = 0; k < t_eff; k++) begin
            ti = int'(branch_phase) + k * l_eff;
            h = (ti < COEF_DEPTH) ? longint'(proto_taps[ti]) : 0;
            acc_re += h * longint'(delay_re[k]);
            acc_im += h * longint'(delay_im[k]);
         end
         o.re = round_to_sample(acc_re);
         o.im = round_to_sample(acc_im);
         o.last = 1'b0;
         expected_outputs.push_back(o);
         n++;
         branch_phase = branch_phase + PHASE_BITS'(d_eff);
      end
      // phase at or above L on entry: nothing emitted, L still taken off
      branch_phase = branch_phase - PHASE_BITS'(l_eff);
      if (n > 0) expected_outputs[$].last = 1'b1;
   endfunction

   // request driver
   always @(posedge clock) begin
      request_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
            nxt = pending_reqs.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.req_type  <= nxt.kind;
            req_bus.tap_index <= nxt.tap_index;
            req_bus.tap_value <= nxt.tap_value;
            req_bus.sample_re <= nxt.re;
            req_bus.sample_im <= nxt.im;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= gap_pct);
      end
   end

   // monitor: tracks config writes, predicts on each request, checks each result
   always @(posedge clock) begin
      request_type    r;
      out_sample_type want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_INTERP: cfg_interp = csr_wdata;
               CSR_DECIM:  cfg_decim = csr_wdata;
               CSR_TAPS:   cfg_taps = csr_wdata;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            r.kind = req_bus.req_type;
            r.tap_index = req_bus.tap_index;
            r.tap_value = req_bus.tap_value;
            r.re = req_bus.sample_re;
            r.im = req_bus.sample_im;
            resample_request(r);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_outputs.size() == 0) begin
               errors++;
               $error("unexpected result: out_re %0d out_im %0d run_last %0d",
                      rsp_bus.out_re, rsp_bus.out_im, rsp_bus.run_last);
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_bus.out_re !== want.re) begin
                  errors++;
                  $error("out_re: expected %0d, got %0d", want.re, rsp_bus.out_re);
               end
               if (rsp_bus.out_im !== want.im) begin
                  errors++;
                  $error("out_im: expected %0d, got %0d", want.im, rsp_bus.out_im);
               end
               if (rsp_bus.run_last !== want.last) begin
                  errors++;
                  $error("run_last: expected %0d, got %0d", want.last, rsp_bus.run_last);
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      int pick;
      pick = $urandom_range(19);
      if (pick == 0) return 16'sh7fff;
      if (pick == 1) return 16'sh8000;
      return SAMPLE_BITS'($urandom);
   endfunction

   function automatic logic signed [COEF_BITS-1:0] rand_coef();
      logic signed [COEF_BITS-1:0] v;
      v = COEF_BITS'($urandom);
      return v >>> $urandom_range(3);
   endfunction

   function automatic logic [CFG_BITS-1:0] rand_cfg();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return '0;
      if (pick < 16) return CFG_BITS'($urandom_range(17, 31));
      return CFG_BITS'($urandom_range(1, 16));
   endfunction

   // ignored fields of each request carry random values
   task automatic queue_coef(input logic [7:0] idx, input logic signed [COEF_BITS-1:0] val);
      request_type r;
      r.kind = REQ_COEF;
      r.tap_index = idx;
      r.tap_value = val;
      r.re = SAMPLE_BITS'($urandom);
      r.im = SAMPLE_BITS'($urandom);
      pending_reqs.push_back(r);
   endtask

   task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] re,
                               input logic signed [SAMPLE_BITS-1:0] im);
      request_type r;
      r.kind = REQ_SAMPLE;
      r.tap_index = 8'($urandom);
      r.tap_value = COEF_BITS'($urandom);
      r.re = re;
      r.im = im;
      pending_reqs.push_back(r);
   endtask

   // checked at the falling edge so that every update of the rising edge has landed
   task automatic wait_for_outputs();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_bus.valid || expected_outputs.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] index,
                            input logic [CFG_BITS-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // block is idle here: nothing pending and the last result's sample fully retired
   task automatic reconfigure(input logic [CFG_BITS-1:0] l, input logic [CFG_BITS-1:0] d,
                              input logic [CFG_BITS-1:0] t);
      wait_for_outputs();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_INTERP, l);
      write_csr(CSR_DECIM, d);
      write_csr(CSR_TAPS, t);
   endtask

   initial begin
      int p, i, span;
      logic [CFG_BITS-1:0] l, d, t;
      foreach (delay_re[k]) begin
         delay_re[k] = '0;
         delay_im[k] = '0;
      end
      foreach (proto_taps[k]) proto_taps[k] = '0;
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_COEF;
      req_bus.tap_index = '0;
      req_bus.tap_value = '0;
      req_bus.sample_re = '0;
      req_bus.sample_im = '0;
      rsp_bus.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: coefficient extremes, sample extremes, saturation
      reconfigure(CFG_BITS'(4), CFG_BITS'(3), CFG_BITS'(4));
      queue_coef(8'd0, 18'sh1ffff);
      queue_coef(8'd1, 18'sh20000);
      queue_coef(8'd2, 18'sd16384);
      queue_coef(8'd3, -18'sd1);
      queue_coef(8'd4, 18'sd32768);
      queue_coef(8'd255, -18'sd77);
      queue_coef(8'd128, 18'sd1);
      queue_sample(16'sh7fff, 16'sh7fff);
      queue_sample(16'sh8000, 16'sh8000);
      queue_sample(16'sh7fff, 16'sh8000);
      queue_sample(16'sd0, 16'sd0);
      queue_sample(-16'sd1, 16'sd1);
      queue_sample(16'sd12345, -16'sd12345);
      // decimation above interpolation: some samples emit nothing
      reconfigure(CFG_BITS'(2), CFG_BITS'(5), CFG_BITS'(1));
      repeat (4) queue_sample(rand_sample(), rand_sample());
      // zero in every register acts as one
      reconfigure('0, '0, '0);
      repeat (2) queue_sample(rand_sample(), rand_sample());
      // over range acts as the maximum
      reconfigure(CFG_BITS'(31), CFG_BITS'(31), CFG_BITS'(31));
      repeat (3) queue_sample(rand_sample(), rand_sample());
      // most results per sample, reaching the top tap
      reconfigure(CFG_BITS'(16), CFG_BITS'(1), CFG_BITS'(16));
      repeat (2) queue_sample(rand_sample(), rand_sample());

      for (p = 0; p < RANDOM_PHASES; p++) begin
         l = rand_cfg();
         d = rand_cfg();
         t = rand_cfg();
         reconfigure(l, d, t);
         // one whole phase without idling on either side
         gap_pct = (p == 2) ? 0 : 24;
         span = eff_cfg(l) * eff_cfg(t);
         for (i = 0; i < PHASE_REQUESTS; i++) begin
            // sender holds off until every result is back
            if (p == 5 && i == PHASE_REQUESTS / 2) wait_for_outputs();
            if ($urandom_range(3) == 0) begin
               if ($urandom_range(1) == 0) begin
                  queue_coef(8'($urandom_range(span - 1)), rand_coef());
               end else begin
                  queue_coef(8'($urandom), rand_coef());
               end
            end else begin
               queue_sample(rand_sample(), rand_sample());
            end
         end
      end

      wait_for_outputs();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && expected_outputs.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
